// File: design/urdm_pkg.sv
// ----------------------------------------------------------------------------
// urdm_pkg
// shared types, codes and constants of the in request / data matcher
// ----------------------------------------------------------------------------
package urdm_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int SEQ_W    = 32;
  localparam int EP_W     = 4;
  localparam int LEN_W    = 7;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 7;

  // parameter defaults
  localparam int DEF_ENDPOINTS   = 16;
  localparam int DEF_MAX_PAYLOAD = 64;

  // queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 7'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 7'd104;

  localparam logic DIR_OUT = 1'b0;
  localparam logic DIR_IN  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_EVENT  = 2'd0,
    CMD_IN     = 2'd1,
    CMD_OUT    = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_e_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BUFFERED   = 3'd0,
    KIND_RET_SUBMIT = 3'd1,
    KIND_RET_UNLINK = 3'd2,
    KIND_DROPPED    = 3'd3,
    KIND_IGNORED    = 3'd4
  } kind_e_t;

  // classified command as it waits between front and back
  typedef struct packed {
    cmd_e_t             cmd;
    logic [SEQ_W-1:0]   seqnum;
    logic [EP_W-1:0]    endpoint;
    logic               ep_ok;
    logic [LEN_W-1:0]   length;
    logic               len_zero;
    logic [SEQ_W-1:0]   target_seqnum;
  } cmd_t;

  typedef struct packed {
    kind_e_t               kind;
    logic [SEQ_W-1:0]      seqnum;
    logic [EP_W-1:0]       endpoint;
    logic                  direction;
    logic [STATUS_W-1:0]   status;
    logic [LEN_W-1:0]      length;
    logic                  from_buffer;
  } result_t;

endpackage

// File: design/usb_in_request_data_matcher.sv
// ----------------------------------------------------------------------------
// usb_in_request_data_matcher
// per-endpoint scoreboard pairing host in polls with device data
// ----------------------------------------------------------------------------
// transactions enter through a two-entry command queue (push/full) and replies
// leave through a two-entry result queue (empty/pop), so either side may stall
// without holding up the other. the back end handles a data event, an in
// submit or an out submit in one step, and an unlink in two: the first
// registers a compare of the target seqnum against all parked entries, the
// second picks the lowest matching endpoint and writes the reply. sustained
// rate is one transaction per cycle for submits and events while the result
// queue has room. an in submit on a valid endpoint that finds no buffered data
// parks its seqnum and produces no reply; a later data event on that endpoint
// answers it. the scoreboard needs no clearing pass: valid bits reset at once.
module usb_in_request_data_matcher #(
  parameter int ENDPOINTS   = urdm_pkg::DEF_ENDPOINTS,
  parameter int MAX_PAYLOAD = urdm_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                            clk,
  input  logic                            rst,
  // command side
  input  logic                            push,
  output logic                            full,
  input  logic [urdm_pkg::CMD_W-1:0]      command,
  input  logic [urdm_pkg::SEQ_W-1:0]      seqnum,
  input  logic [urdm_pkg::EP_W-1:0]       endpoint,
  input  logic [urdm_pkg::LEN_W-1:0]      event_length,
  input  logic [urdm_pkg::SEQ_W-1:0]      target_seqnum,
  // reply side
  output logic                            empty,
  input  logic                            pop,
  output logic [urdm_pkg::KIND_W-1:0]     reply_kind,
  output logic [urdm_pkg::SEQ_W-1:0]      reply_seqnum,
  output logic [urdm_pkg::EP_W-1:0]       reply_endpoint,
  output logic                            reply_direction,
  output logic [urdm_pkg::STATUS_W-1:0]   reply_status,
  output logic [urdm_pkg::LEN_W-1:0]      reply_length,
  output logic                            from_buffer
);

  import urdm_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;
  result_t res;
  logic    res_push;
  logic    res_full;
  result_t res_head;
  logic    res_valid;

  // front: classify and queue incoming transactions
  urdm_front #(
    .ENDPOINTS   (ENDPOINTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .seqnum        (seqnum),
    .endpoint      (endpoint),
    .event_length  (event_length),
    .target_seqnum (target_seqnum),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop)
  );

  // back: scoreboard state and unlink search
  urdm_back #(
    .ENDPOINTS (ENDPOINTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // replies wait here until taken
  urdm_queue #(
    .T     (result_t),
    .DEPTH (RESQ_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .valid (res_valid)
  );

  assign empty           = !res_valid;
  assign reply_kind      = res_head.kind;
  assign reply_seqnum    = res_head.seqnum;
  assign reply_endpoint  = res_head.endpoint;
  assign reply_direction = res_head.direction;
  assign reply_status    = res_head.status;
  assign reply_length    = res_head.length;
  assign from_buffer     = res_head.from_buffer;

`ifndef NO_ASSERTIONS
  // the back end never writes a reply into a full result queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("reply pushed into full result queue");

  // a command is consumed only when one is waiting
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // no reply is visible right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");
`endif

endmodule

// File: design/urdm_queue.sv
// ----------------------------------------------------------------------------
// urdm_queue
// small register queue with push/full and pop/valid sides
// ----------------------------------------------------------------------------
module urdm_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: design/urdm_front.sv
// ----------------------------------------------------------------------------
// urdm_front
// accepts transactions, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module urdm_front #(
  parameter int ENDPOINTS   = urdm_pkg::DEF_ENDPOINTS,
  parameter int MAX_PAYLOAD = urdm_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [urdm_pkg::CMD_W-1:0]   command,
  input  logic [urdm_pkg::SEQ_W-1:0]   seqnum,
  input  logic [urdm_pkg::EP_W-1:0]    endpoint,
  input  logic [urdm_pkg::LEN_W-1:0]   event_length,
  input  logic [urdm_pkg::SEQ_W-1:0]   target_seqnum,
  output urdm_pkg::cmd_t               cmd,
  output logic                         cmd_valid,
  input  logic                         cmd_pop
);

  import urdm_pkg::*;

  cmd_t in_cmd;

  // saturate oversized events, flag zero length and out of range endpoints
  always_comb begin
    in_cmd.cmd           = cmd_e_t'(command);
    in_cmd.seqnum        = seqnum;
    in_cmd.endpoint      = endpoint;
    in_cmd.ep_ok         = (32'(endpoint) < 32'(ENDPOINTS));
    in_cmd.length        = (32'(event_length) > 32'(MAX_PAYLOAD)) ?
                           LEN_W'(MAX_PAYLOAD) : event_length;
    in_cmd.len_zero      = (event_length == '0);
    in_cmd.target_seqnum = target_seqnum;
  end

  urdm_queue #(
    .T     (cmd_t),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .valid (cmd_valid)
  );

endmodule

// File: design/urdm_back.sv
// ----------------------------------------------------------------------------
// urdm_back
// endpoint scoreboard: parks in requests, buffers data, resolves unlinks
// ----------------------------------------------------------------------------
module urdm_back #(
  parameter int ENDPOINTS = urdm_pkg::DEF_ENDPOINTS
) (
  input  logic              clk,
  input  logic              rst,
  input  urdm_pkg::cmd_t    cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output urdm_pkg::result_t res
);

  import urdm_pkg::*;

  localparam int IDX_W = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MATCH = 2'b10
  } back_state_t;

  back_state_t          state;
  back_state_t          state_next;

  logic [ENDPOINTS-1:0] parked_valid;
  logic [SEQ_W-1:0]     parked_seqnum [ENDPOINTS];
  logic [ENDPOINTS-1:0] buffer_ready;
  logic [LEN_W-1:0]     buffer_length [ENDPOINTS];

  logic [ENDPOINTS-1:0] match_raw;
  logic [ENDPOINTS-1:0] match_vec;
  logic [ENDPOINTS-1:0] match_low;
  logic [SEQ_W-1:0]     cancel_seqnum;

  logic [IDX_W-1:0]     idx;
  logic                 pv;
  logic                 br;
  logic                 exec;
  logic                 set_parked;
  logic                 clr_parked;
  logic                 set_buffer;
  logic                 clr_buffer;
  logic                 load_match;
  logic                 unlink_done;

  assign idx = cmd.endpoint[IDX_W-1:0];
  assign pv  = cmd.ep_ok && parked_valid[idx];
  assign br  = cmd.ep_ok && buffer_ready[idx];

  // every parked entry compared against the unlink target at once
  always_comb begin
    for (int i = 0; i < ENDPOINTS; i++) begin
      match_raw[i] = parked_valid[i] && (parked_seqnum[i] == cmd.target_seqnum);
    end
  end

  // lowest endpoint wins
  assign match_low = match_vec & (~match_vec + 1'b1);

  assign exec = (state == ST_IDLE) && cmd_valid &&
                ((cmd.cmd == CMD_CANCEL) || !res_full);

  always_comb begin
    state_next  = state;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res         = '0;
    set_parked  = 1'b0;
    clr_parked  = 1'b0;
    set_buffer  = 1'b0;
    clr_buffer  = 1'b0;
    load_match  = 1'b0;
    unlink_done = 1'b0;
    case (state)
      ST_IDLE: begin
        if (exec) begin
          cmd_pop      = 1'b1;
          res.endpoint = cmd.endpoint;
          case (cmd.cmd)
            CMD_EVENT: begin
              res_push      = 1'b1;
              res.direction = DIR_IN;
              res.length    = cmd.length;
              if (cmd.len_zero) begin
                res.kind   = KIND_IGNORED;
                res.length = '0;
              end else if (!cmd.ep_ok) begin
                res.kind = KIND_DROPPED;
              end else if (pv) begin
                res.kind   = KIND_RET_SUBMIT;
                res.seqnum = parked_seqnum[idx];
                clr_parked = 1'b1;
              end else if (br) begin
                res.kind = KIND_DROPPED;
              end else begin
                res.kind   = KIND_BUFFERED;
                set_buffer = 1'b1;
              end
            end
            CMD_IN: begin
              res.kind      = KIND_RET_SUBMIT;
              res.seqnum    = cmd.seqnum;
              res.direction = DIR_IN;
              if (!cmd.ep_ok) begin
                res_push = 1'b1;
              end else if (br) begin
                res_push        = 1'b1;
                res.length      = buffer_length[idx];
                res.from_buffer = 1'b1;
                clr_buffer      = 1'b1;
              end else begin
                // parked: no reply until data shows up
                set_parked = 1'b1;
              end
            end
            CMD_OUT: begin
              res_push      = 1'b1;
              res.kind      = KIND_RET_SUBMIT;
              res.seqnum    = cmd.seqnum;
              res.direction = DIR_OUT;
            end
            CMD_CANCEL: begin
              load_match = 1'b1;
              state_next = ST_MATCH;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_MATCH: begin
        if (!res_full) begin
          res_push      = 1'b1;
          unlink_done   = 1'b1;
          res.kind      = KIND_RET_UNLINK;
          res.seqnum    = cancel_seqnum;
          res.endpoint  = '0;
          res.direction = DIR_OUT;
          res.status    = (|match_vec) ? STATUS_OK : STATUS_NOT_FOUND;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      parked_valid <= '0;
      buffer_ready <= '0;
    end else begin
      state <= state_next;
      if (set_parked) begin
        parked_valid[idx] <= 1'b1;
      end
      if (clr_parked) begin
        parked_valid[idx] <= 1'b0;
      end
      if (unlink_done) begin
        parked_valid <= parked_valid & ~match_low;
      end
      if (set_buffer) begin
        buffer_ready[idx] <= 1'b1;
      end
      if (clr_buffer) begin
        buffer_ready[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_parked) begin
      parked_seqnum[idx] <= cmd.seqnum;
    end
    if (set_buffer) begin
      buffer_length[idx] <= cmd.length;
    end
    if (load_match) begin
      match_vec     <= match_raw;
      cancel_seqnum <= cmd.seqnum;
    end
  end

endmodule
